// ===== rtl/tbg_pkg.sv =====
// Shared constants, types and coefficient tables of the text box geometry decoder.
package tbg_pkg;

    // Map bounds and configuration register map
    localparam int MAP_SIZE = 128;
    localparam logic [1:0] REG_THRESHOLD_ADDR = 2'd0;
    localparam logic [15:0] THRESH_RESET = 16'd32768;

    // Angle reduction in Q.29 radians
    localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [33:0] PI_Q29_S = 34'sd1686629713;
    localparam logic signed [33:0] THREE_HALF_PI_Q29 = 34'sd2529944571;
    localparam logic signed [31:0] RED_T1 = 32'sd421657428;
    localparam logic signed [31:0] RED_T2 = 32'sd1264972285;
    localparam logic signed [31:0] RED_T3 = 32'sd2108287142;
    localparam logic signed [31:0] RED_NT1 = -32'sd421657428;
    localparam logic signed [31:0] RED_NT2 = -32'sd1264972285;
    localparam logic signed [31:0] RED_NT3 = -32'sd2108287142;

    // Polynomial datapath widths
    localparam int X2_W = 30;
    localparam int T_W = 31;
    localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

    // Horner divisors, innermost first
    localparam int SIN_STEPS = 3;
    localparam int COS_STEPS = 4;
    localparam int SIN_DIV [SIN_STEPS] = '{42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{56, 30, 12, 2};

    // Radians to degrees: dmag = round((amag * 180 * 2^24) / pi_q29)
    localparam int DEG_SHIFT = 20;
    localparam logic [63:0] DEG_A = 64'd3019898880;
    localparam logic [63:0] DEG_P = 64'd1686629713;
    localparam logic [63:0] DEG_B = 64'd843314856;
    localparam logic [63:0] DEG_K = (DEG_A << DEG_SHIFT) / DEG_P;
    localparam logic [63:0] DEG_HS = (64'd1 << (DEG_SHIFT - 1)) - 64'd1;

    // Centre saturation bounds, Q12.6
    localparam logic signed [20:0] CENTER_MAX = 21'sd131071;
    localparam logic signed [20:0] CENTER_MIN = -21'sd131072;

    // Pipeline depth of the side band
    localparam int SIDE_LEN = 13;

    // Quarter turn taken off the angle
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

    // Per-request data carried alongside the polynomial cells
    typedef struct packed {
        logic [6:0]         col;
        logic [6:0]         row;
        logic [15:0]        score;
        logic [15:0]        dt;
        logic [15:0]        dr;
        logic [15:0]        db;
        logic [15:0]        dl;
        logic signed [15:0] ang;
        logic [X2_W-1:0]    ax;
        t_quad              quad;
        logic               neg;
    } t_side;

endpackage

// ===== rtl/text_box_geometry_decode.sv =====
// Top level of the rotated text box geometry decoder.
//
//  channel   | ports                                 | handshake
//  ----------+---------------------------------------+------------------------------
//  request   | start, busy, i_cell_* i_dist_* i_rot  | taken when start & !busy
//  result    | o_valid, o_center_* o_box_* o_angle.. | one cycle strobe, no backpressure
//  config    | psel penable pwrite paddr pwdata ...  | APB write, pready tied high
//
//  A request is accepted every cycle; busy is never raised and nothing stalls.
//  A kept request passes in order through the input register, the square,
//  four cosine Horner cells of two stages each (the three sine cells run
//  beside them), then quadrant, product, partial sum and output stages to its result.
//  A dropped request (low score or off the map) leaves a bubble and no strobe.
//  Reset is synchronous, active low, clears the valid line and sets the threshold to its reset value.
module text_box_geometry_decode import tbg_pkg::*; #(
    parameter int MAP_DIM = MAP_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [6:0]         i_cell_col,
    input  logic [6:0]         i_cell_row,
    input  logic [15:0]        i_cell_score,
    input  logic [15:0]        i_dist_top,
    input  logic [15:0]        i_dist_right,
    input  logic [15:0]        i_dist_bottom,
    input  logic [15:0]        i_dist_left,
    input  logic signed [15:0] i_rot_angle,
    output logic               o_valid,
    output logic signed [17:0] o_center_x,
    output logic signed [17:0] o_center_y,
    output logic [16:0]        o_box_width,
    output logic [16:0]        o_box_height,
    output logic signed [16:0] o_angle_degrees,
    output logic [15:0]        o_score_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]        r_thr;
    t_side              r_side [SIDE_LEN];
    logic [SIDE_LEN-1:0] r_vld;
    t_side              n_side;
    logic               keep;

    logic signed [31:0] rad;
    logic signed [2:0]  q;
    logic signed [33:0] off;
    logic signed [33:0] red;
    logic [33:0]        red_mag;

    logic [59:0]        sq;
    logic [X2_W-1:0]    r_x2;

    logic [X2_W-1:0]    sin_x2 [SIN_STEPS+1];
    logic [T_W-1:0]     sin_t  [SIN_STEPS+1];
    logic [X2_W-1:0]    cos_x2 [COS_STEPS+1];
    logic [T_W-1:0]     cos_t  [COS_STEPS+1];

    logic [60:0]        sv_prod;
    logic [X2_W-1:0]    r_sv;
    logic [X2_W-1:0]    r_sv2;
    logic [30:0]        s_rnd;
    logic [31:0]        c_rnd;
    logic signed [15:0] s_m;
    logic signed [15:0] c_m;
    logic signed [15:0] n_sin;
    logic signed [15:0] n_cos;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    logic signed [35:0] sin_e, cos_e, dr_e, db_e, h_e, w_e;
    logic signed [35:0] r_pcdr, r_psdb, r_psh, r_pcw;
    logic signed [35:0] r_psdr, r_pcdb, r_pch, r_psw;
    logic signed [35:0] r_xa, r_xb, r_ya, r_yb;
    logic signed [35:0] x_sum, y_sum;
    logic signed [20:0] x_q6, y_q6;

    logic [15:0]        amag;
    logic [36:0]        r_dprod;
    logic [47:0]        r_dnum;
    logic [36:0]        dq_sum;
    logic [16:0]        dq0;
    logic [16:0]        r_dq;
    logic [47:0]        r_dqp;
    logic [47:0]        r_dnum2;
    logic [47:0]        drem;
    logic [16:0]        r_dmag;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_THRESHOLD_ADDR) ? {16'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_THRESHOLD_ADDR)) begin
            r_thr <= pwdata[15:0];
        end
    end

    // Keep only cells on the map that pass the threshold
    assign busy = 1'b0;
    assign keep = start && !busy && (i_cell_score >= r_thr)
               && (32'(i_cell_col) < 32'(MAP_DIM)) && (32'(i_cell_row) < 32'(MAP_DIM));

    // Reduce the angle by whole quarter turns into [-pi/4, pi/4]
    assign rad = {i_rot_angle, 16'd0};

    always_comb begin
        if (rad > RED_T3) begin
            q = 3'sd3;
        end else if (rad > RED_T2) begin
            q = 3'sd2;
        end else if (rad > RED_T1) begin
            q = 3'sd1;
        end else if (rad < RED_NT3) begin
            q = -3'sd3;
        end else if (rad < RED_NT2) begin
            q = -3'sd2;
        end else if (rad < RED_NT1) begin
            q = -3'sd1;
        end else begin
            q = 3'sd0;
        end
        case (q)
            3'sd3:   off = THREE_HALF_PI_Q29;
            3'sd2:   off = PI_Q29_S;
            3'sd1:   off = HALF_PI_Q29;
            -3'sd1:  off = -HALF_PI_Q29;
            -3'sd2:  off = -PI_Q29_S;
            -3'sd3:  off = -THREE_HALF_PI_Q29;
            default: off = 34'sd0;
        endcase
        red     = 34'(rad) - off;
        red_mag = red[33] ? 34'(-red) : 34'(red);
    end

    always_comb begin
        n_side.col   = i_cell_col;
        n_side.row   = i_cell_row;
        n_side.score = i_cell_score;
        n_side.dt    = i_dist_top;
        n_side.dr    = i_dist_right;
        n_side.db    = i_dist_bottom;
        n_side.dl    = i_dist_left;
        n_side.ang   = i_rot_angle;
        n_side.ax    = {red_mag[28:0], 1'b0};
        n_side.quad  = t_quad'(q[1:0]);
        n_side.neg   = red[33];
    end

    // Advance the side band and its valid line
    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k < SIDE_LEN; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[SIDE_LEN-2:0], keep};
            o_valid <= r_vld[SIDE_LEN-1];
        end
    end

    // Square of the reduced angle
    assign sq = 60'(r_side[0].ax) * 60'(r_side[0].ax);

    always_ff @(posedge i_clk) begin
        r_x2 <= sq[59:30];
    end

    // Sine and cosine Horner chains
    assign sin_x2[0] = r_x2;
    assign sin_t[0]  = ONE_Q30;
    assign cos_x2[0] = r_x2;
    assign cos_t[0]  = ONE_Q30;

    for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
        tbg_horner_cell #(.DIV(SIN_DIV[g])) u_cell (
            .i_clk (i_clk),
            .i_x2  (sin_x2[g]),
            .i_t   (sin_t[g]),
            .o_x2  (sin_x2[g+1]),
            .o_t   (sin_t[g+1])
        );
    end

    for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
        tbg_horner_cell #(.DIV(COS_DIV[g])) u_cell (
            .i_clk (i_clk),
            .i_x2  (cos_x2[g]),
            .i_t   (cos_t[g]),
            .o_x2  (cos_x2[g+1]),
            .o_t   (cos_t[g+1])
        );
    end

    // Final sine multiply by the angle, then an extra register to meet cosine
    assign sv_prod = 61'(r_side[7].ax) * 61'(sin_t[SIN_STEPS]);

    always_ff @(posedge i_clk) begin
        r_sv  <= sv_prod[59:30];
        r_sv2 <= r_sv;
    end

    // Round to Q1.14 and apply the quadrant
    assign s_rnd = 31'(r_sv2) + 31'd32768;
    assign c_rnd = 32'(cos_t[COS_STEPS]) + 32'd32768;

    always_comb begin
        s_m = r_side[9].neg ? -$signed({1'b0, s_rnd[30:16]}) : $signed({1'b0, s_rnd[30:16]});
        c_m = $signed(c_rnd[31:16]);
        case (r_side[9].quad)
            QUAD_0: begin
                n_sin = s_m;
                n_cos = c_m;
            end
            QUAD_90: begin
                n_sin = c_m;
                n_cos = -s_m;
            end
            QUAD_180: begin
                n_sin = -s_m;
                n_cos = -c_m;
            end
            QUAD_270: begin
                n_sin = -c_m;
                n_cos = s_m;
            end
            default: begin
                n_sin = s_m;
                n_cos = c_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    // Products of the rotation terms with the distances
    assign sin_e = 36'(r_sin);
    assign cos_e = 36'(r_cos);
    assign dr_e  = {20'd0, r_side[10].dr};
    assign db_e  = {20'd0, r_side[10].db};
    assign h_e   = {19'd0, 17'(r_side[10].dt) + 17'(r_side[10].db)};
    assign w_e   = {19'd0, 17'(r_side[10].dr) + 17'(r_side[10].dl)};

    always_ff @(posedge i_clk) begin
        r_pcdr <= (cos_e * dr_e) <<< 1;
        r_psdb <= (sin_e * db_e) <<< 1;
        r_psh  <= sin_e * h_e;
        r_pcw  <= cos_e * w_e;
        r_psdr <= (sin_e * dr_e) <<< 1;
        r_pcdb <= (cos_e * db_e) <<< 1;
        r_pch  <= cos_e * h_e;
        r_psw  <= sin_e * w_e;
    end

    // Partial sums with the cell offset in Q.21
    always_ff @(posedge i_clk) begin
        r_xa <= $signed({6'd0, r_side[11].col, 23'd0}) + r_pcdr + r_psdb;
        r_xb <= -r_psh - r_pcw;
        r_ya <= $signed({6'd0, r_side[11].row, 23'd0}) - r_psdr + r_pcdb;
        r_yb <= -r_pch + r_psw;
    end

    // Round half up to Q.6 and saturate
    assign x_sum = r_xa + r_xb + 36'sd16384;
    assign y_sum = r_ya + r_yb + 36'sd16384;
    assign x_q6  = 21'(x_sum >>> 15);
    assign y_q6  = 21'(y_sum >>> 15);

    // Radians to degrees: reciprocal estimate, exact numerator
    assign amag = r_side[9].ang[15] ? 16'(-r_side[9].ang) : 16'(r_side[9].ang);

    always_ff @(posedge i_clk) begin
        r_dprod <= 37'(amag) * 37'(DEG_K[20:0]);
        r_dnum  <= 48'(amag) * 48'(DEG_A[31:0]) + 48'(DEG_B[31:0]);
    end

    assign dq_sum = r_dprod + 37'(DEG_HS[19:0]);
    assign dq0    = 17'(dq_sum >> DEG_SHIFT);

    always_ff @(posedge i_clk) begin
        r_dq    <= dq0;
        r_dqp   <= 48'(dq0) * 48'(DEG_P[30:0]);
        r_dnum2 <= r_dnum;
    end

    // One correction step on the remainder
    assign drem = r_dnum2 - r_dqp;

    always_ff @(posedge i_clk) begin
        r_dmag <= r_dq + ((drem >= 48'(DEG_P[30:0])) ? 17'd1 : 17'd0);
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        if (x_q6 > CENTER_MAX) begin
            o_center_x <= 18'(CENTER_MAX);
        end else if (x_q6 < CENTER_MIN) begin
            o_center_x <= 18'(CENTER_MIN);
        end else begin
            o_center_x <= 18'(x_q6);
        end
        if (y_q6 > CENTER_MAX) begin
            o_center_y <= 18'(CENTER_MAX);
        end else if (y_q6 < CENTER_MIN) begin
            o_center_y <= 18'(CENTER_MIN);
        end else begin
            o_center_y <= 18'(y_q6);
        end
        o_box_width     <= 17'(r_side[12].dr) + 17'(r_side[12].dl);
        o_box_height    <= 17'(r_side[12].dt) + 17'(r_side[12].db);
        o_angle_degrees <= r_side[12].ang[15] ? $signed(r_dmag) : -$signed(r_dmag);
        o_score_out     <= r_side[12].score;
    end

endmodule

// ===== rtl/tbg_horner_cell.sv =====
// One Horner step cell: t_out = 1 - (x2 * t_in) / DIV, in Q.30, two register stages.
module tbg_horner_cell import tbg_pkg::*; #(
    parameter int DIV = 2
) (
    input  logic            i_clk,
    input  logic [X2_W-1:0] i_x2,
    input  logic [T_W-1:0]  i_t,
    output logic [X2_W-1:0] o_x2,
    output logic [T_W-1:0]  o_t
);

    localparam int K = $clog2(DIV);
    localparam logic [63:0] RECIP = ((64'd1 << (X2_W + K)) + 64'(DIV) - 64'd1) / 64'(DIV);

    logic [X2_W-1:0] r_p;
    logic [X2_W-1:0] r_x2a;
    logic [X2_W-1:0] r_x2b;
    logic [T_W-1:0]  r_t;
    logic [60:0]     prod;
    logic [61:0]     qprod;
    logic [61:0]     qsh;
    logic [T_W-1:0]  n_t;

    // Product of x2 and the running term
    assign prod = 61'(i_x2) * 61'(i_t);

    // Divide by the constant through its reciprocal
    assign qprod = 62'(r_p) * 62'(RECIP[31:0]);
    assign qsh   = qprod >> (X2_W + K);
    assign n_t   = ONE_Q30 - qsh[T_W-1:0];

    // Advance both stages and hand x2 to the neighbor
    always_ff @(posedge i_clk) begin
        r_p   <= prod[59:30];
        r_x2a <= i_x2;
        r_t   <= n_t;
        r_x2b <= r_x2a;
    end

    assign o_x2 = r_x2b;
    assign o_t  = r_t;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the rotated text box geometry decoder.
`default_nettype none

module tb_top import tbg_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // One map cell as presented on the request ports
    typedef struct {
        logic [6:0]         col;
        logic [6:0]         row;
        logic [15:0]        score;
        logic [15:0]        dt;
        logic [15:0]        dr;
        logic [15:0]        db;
        logic [15:0]        dl;
        logic signed [15:0] ang;
    } t_cell;

    // One decoded box as seen on the result ports
    typedef struct packed {
        logic [17:0] cx;
        logic [17:0] cy;
        logic [16:0] w;
        logic [16:0] h;
        logic [16:0] deg;
        logic [15:0] score;
    } t_box;

    // Box predictor and pending box store
    class t_box_scoreboard;
        t_box        pending_boxes[$];
        logic [15:0] threshold;
        int          mismatches;
        int          boxes_seen;
        int          cells_taken;

        function new();
            threshold = THRESH_RESET;
            mismatches = 0;
            boxes_seen = 0;
            cells_taken = 0;
        endfunction

        function automatic longint mul30(longint unsigned a, longint unsigned b);
            return (a * b) >> 30;
        endfunction

        // Fixed point sine and cosine in Q1.14 of a Q3.13 angle
        function automatic void sin_cos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
            longint          r;
            int              quarter;
            bit              neg;
            longint unsigned ax, sq, t, sv, cv;
            longint          s14, c14;
            r = longint'(ang) * 65536;
            quarter = 0;
            while (r > longint'(HALF_PI_Q29) / 2) begin
                r -= longint'(HALF_PI_Q29);
                quarter++;
            end
            while (r < -(longint'(HALF_PI_Q29) / 2)) begin
                r += longint'(HALF_PI_Q29);
                quarter--;
            end
            neg = r < 0;
            ax = (neg ? -r : r) << 1;
            sq = mul30(ax, ax);
            t = 64'd1073741824 - sq / 42;
            t = 64'd1073741824 - mul30(sq, t) / 20;
            t = 64'd1073741824 - mul30(sq, t) / 6;
            sv = mul30(ax, t);
            cv = 64'd1073741824 - sq / 56;
            cv = 64'd1073741824 - mul30(sq, cv) / 30;
            cv = 64'd1073741824 - mul30(sq, cv) / 12;
            cv = 64'd1073741824 - mul30(sq, cv) / 2;
            s14 = longint'((sv + 32768) >> 16);
            c14 = longint'((cv + 32768) >> 16);
            if (neg) s14 = -s14;
            case (quarter & 3)
                0: begin s = s14;  c = c14;  end
                1: begin s = c14;  c = -s14; end
                2: begin s = -s14; c = -c14; end
                default: begin s = -c14; c = s14; end
            endcase
        endfunction

        // Round Q.21 half up to Q.6 and saturate
        function automatic logic [17:0] round_center(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 131071) r = 131071;
            if (r < -131072) r = -131072;
            return r[17:0];
        endfunction

        // Note an accepted cell and queue its box when it is kept
        function void note_cell(t_cell k);
            longint          s, c, h, w, xs, ys, dg;
            longint unsigned amag, dmag;
            t_box            b;
            cells_taken++;
            if (k.col >= MAP_SIZE || k.row >= MAP_SIZE) return;
            if (k.score < threshold) return;
            sin_cos(k.ang, s, c);
            h = longint'(k.dt) + longint'(k.db);
            w = longint'(k.dr) + longint'(k.dl);
            xs = (longint'(k.col) << 23) + 2 * c * k.dr + 2 * s * k.db - s * h - c * w;
            ys = (longint'(k.row) << 23) - 2 * s * k.dr + 2 * c * k.db - c * h + s * w;
            amag = (k.ang < 0) ? -longint'(k.ang) : longint'(k.ang);
            dmag = ((amag * 180) << 24);
            dmag = (dmag + 64'd843314856) / 64'd1686629713;
            dg = (k.ang < 0) ? longint'(dmag) : -longint'(dmag);
            b.cx = round_center(xs);
            b.cy = round_center(ys);
            b.w = w[16:0];
            b.h = h[16:0];
            b.deg = dg[16:0];
            b.score = k.score;
            pending_boxes.insert(pending_boxes.size(), b);
        endfunction

        // Compare a produced box against the oldest pending one
        function void check_box(t_box a);
            t_box e;
            boxes_seen++;
            if (pending_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected box cx=%0h cy=%0h", a.cx, a.cy);
                return;
            end
            e = pending_boxes.pop_front();
            if (a != e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: box mismatch exp cx=%0h cy=%0h w=%0h h=%0h deg=%0h s=%0h",
                             e.cx, e.cy, e.w, e.h, e.deg, e.score);
                if (mismatches <= 10)
                    $display("       got cx=%0h cy=%0h w=%0h h=%0h deg=%0h s=%0h",
                             a.cx, a.cy, a.w, a.h, a.deg, a.score);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [6:0]         i_cell_col;
    logic [6:0]         i_cell_row;
    logic [15:0]        i_cell_score;
    logic [15:0]        i_dist_top;
    logic [15:0]        i_dist_right;
    logic [15:0]        i_dist_bottom;
    logic [15:0]        i_dist_left;
    logic signed [15:0] i_rot_angle;
    logic               o_valid;
    logic signed [17:0] o_center_x;
    logic signed [17:0] o_center_y;
    logic [16:0]        o_box_width;
    logic [16:0]        o_box_height;
    logic signed [16:0] o_angle_degrees;
    logic [15:0]        o_score_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    t_box_scoreboard sb = new();
    int              cycle_count = 0;
    bit              no_idle = 0;

    text_box_geometry_decode DUT (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Note accepted requests and check strobed boxes
    always @(posedge i_clk) begin
        t_box  got;
        t_cell k;
        if (i_rst_n && start && !busy) begin
            k.col = i_cell_col;
            k.row = i_cell_row;
            k.score = i_cell_score;
            k.dt = i_dist_top;
            k.dr = i_dist_right;
            k.db = i_dist_bottom;
            k.dl = i_dist_left;
            k.ang = i_rot_angle;
            sb.note_cell(k);
        end
        if (i_rst_n && o_valid) begin
            got.cx = o_center_x;
            got.cy = o_center_y;
            got.w = o_box_width;
            got.h = o_box_height;
            got.deg = o_angle_degrees;
            got.score = o_score_out;
            sb.check_box(got);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one request and hold it until it is taken
    task automatic send_cell(t_cell k);
        if (!no_idle && $urandom_range(99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cell_col <= k.col;
        i_cell_row <= k.row;
        i_cell_score <= k.score;
        i_dist_top <= k.dt;
        i_dist_right <= k.dr;
        i_dist_bottom <= k.db;
        i_dist_left <= k.dl;
        i_rot_angle <= k.ang;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drain the pipe, then write the threshold register
    task automatic write_threshold(logic [15:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_boxes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_THRESHOLD_ADDR;
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.threshold = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic t_cell make_cell(int col, int row, int score, int dt, int dr,
                                        int db, int dl, int ang);
        t_cell k;
        k.col = 7'(col);
        k.row = 7'(row);
        k.score = 16'(score);
        k.dt = 16'(dt);
        k.dr = 16'(dr);
        k.db = 16'(db);
        k.dl = 16'(dl);
        k.ang = 16'(ang);
        return k;
    endfunction

    // Random cell: mostly kept scores, mixed distance and angle ranges
    function automatic t_cell random_cell(logic [15:0] thr);
        t_cell k;
        int    pick;
        k.col = 7'($urandom_range(127));
        k.row = 7'($urandom_range(127));
        pick = int'($urandom_range(9));
        if (pick < 7) k.score = 16'($urandom_range(65535, thr));
        else k.score = 16'($urandom_range(65535));
        pick = int'($urandom_range(3));
        k.dt = (pick == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4095));
        k.dr = (pick == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4095));
        k.db = (pick == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4095));
        k.dl = (pick == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(4095));
        pick = int'($urandom_range(2));
        if (pick == 0) k.ang = 16'($urandom_range(12868) - 6434);
        else k.ang = 16'($urandom_range(65535));
        return k;
    endfunction

    initial begin
        logic [15:0] thr_steps[6];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cell_col = '0;
        i_cell_row = '0;
        i_cell_score = '0;
        i_dist_top = '0;
        i_dist_right = '0;
        i_dist_bottom = '0;
        i_dist_left = '0;
        i_rot_angle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, quadrant edges, threshold boundary
        send_cell(make_cell(0, 0, 32768, 0, 0, 0, 0, 0));
        send_cell(make_cell(127, 127, 32767, 100, 100, 100, 100, 0));
        send_cell(make_cell(127, 127, 65535, 65535, 65535, 65535, 65535, 32767));
        send_cell(make_cell(0, 0, 65535, 65535, 65535, 65535, 65535, -32768));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, 6434));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, -6434));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, 6435));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, 12868));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, -12868));
        send_cell(make_cell(64, 32, 40000, 640, 1280, 320, 960, 25736));
        send_cell(make_cell(10, 90, 0, 640, 1280, 320, 960, 1000));
        send_cell(make_cell(127, 0, 65535, 0, 65535, 0, 65535, 1));
        send_cell(make_cell(0, 127, 65535, 65535, 0, 65535, 0, -1));
        send_cell(make_cell(85, 42, 43690, 21845, 43690, 21845, 43690, 21845));
        send_cell(make_cell(42, 85, 21845, 43690, 21845, 43690, 21845, -21846));

        // Random phases across threshold settings, extremes included
        thr_steps = '{THRESH_RESET, 16'd0, 16'd65535, 16'd1, 16'($urandom), THRESH_RESET};
        foreach (thr_steps[p]) begin
            if (p > 0) write_threshold(thr_steps[p]);
            if (p == 3) write_threshold(16'd65534);
            for (int n = 0; n < 108; n++) begin
                no_idle = (p == 2);
                send_cell(random_cell(thr_steps[p]));
            end
            no_idle = 0;
        end

        // Drain
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_boxes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d cells and %0d boxes over seven threshold settings.",
                 sb.cells_taken, sb.boxes_seen);
        if (sb.mismatches == 0 && sb.pending_boxes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_box_geometry_decode.f =====
rtl/tbg_pkg.sv
rtl/tbg_horner_cell.sv
rtl/text_box_geometry_decode.sv
tb/sv/tb_top.sv
